@@ design/spk_pkg.sv @@
package spk_pkg;

  localparam int FIELD_BITS = 16;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ATLAS_WIDTH    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_HEIGHT    = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALLOW_ROTATION = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALLOW_GROWTH   = 8'd3;

  localparam logic [FIELD_BITS-1:0] ATLAS_WIDTH_RESET = 16'd1024;
  localparam logic [FIELD_BITS-1:0] INIT_HEIGHT_RESET = 16'd1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NR_FIT,
    ST_CLOSE,
    ST_WIDE,
    ST_ROT_ORDER,
    ST_ROT_UP,
    ST_ROT_UPW,
    ST_ROT_FLAT,
    ST_ROT_FLATH,
    ST_ROT_PICK,
    ST_NEED,
    ST_GROW,
    ST_PUT,
    ST_SHELF,
    ST_OUT
  } state_t;

endpackage

@@ design/spk_addcmp.sv @@
module spk_addcmp #(
  parameter int W = 17
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] c,
  output logic [W:0]   sum,
  output logic         le
);

  assign sum = {1'b0, a} + {1'b0, b};
  assign le  = (sum <= {1'b0, c});

endmodule

@@ design/shelf_rect_packer_core.sv @@
// Shelf packer for a texture atlas: one rectangle size in, one placement out.
// Input channel in_valid/in_ready carries rect_width and rect_height. Output
// channel out_valid/out_ready carries placed, pos_x, pos_y, placed_width,
// placed_height and atlas_height_now. Configuration writes arrive on
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// One adder-comparator is shared by a sequencer that runs one step of the
// placement per cycle, except while it holds for the output register. A
// rectangle is checked against the current shelf, a new shelf is opened when
// it does not fit, rotation adds orientation checks, and growth mode adds a
// doubling step per height check. One item is in work at a time; in_ready is
// high only while the sequencer is idle, so the next transaction can be taken
// in the cycle the result appears.
// The result sits in an output register; a new transaction may be accepted
// while it waits, and the sequencer holds before writing the next result
// until the receiver takes the previous one.
// Reset clears the shelf state, loads the atlas height with its reset value,
// returns the state and configuration to reset values and clears out_valid.
module shelf_rect_packer_core #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        placed,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] placed_width,
  output logic [15:0] placed_height,
  output logic [15:0] atlas_height_now
);

  localparam int FB = spk_pkg::FIELD_BITS;
  localparam int SW = (COORD_BITS > FB) ? COORD_BITS : FB;
  localparam int UW = SW + 1;
  localparam logic [UW-1:0] COORD_MAX = UW'((64'd1 << COORD_BITS) - 64'd1);

  spk_pkg::state_t state, state_next;

  logic [FB-1:0] atlas_width;
  logic          allow_rotation;
  logic          allow_growth;

  logic [SW-1:0] fill;
  logic [SW-1:0] shelf_h;
  logic [SW-1:0] used;
  logic [SW-1:0] atlas;

  logic [FB-1:0] pw;
  logic [FB-1:0] ph;
  logic [UW-1:0] need;
  logic [SW-1:0] grow_h;
  logic          ok;
  logic [FB-1:0] px;
  logic [FB-1:0] py;

  logic [UW-1:0] op_a, op_b, op_c;
  logic [UW:0]   sum;
  logic          le;
  logic [UW-1:0] grow_dbl;
  logic          grow_ovf;
  logic          out_free;

  spk_addcmp #(.W(UW)) u_addcmp (
    .a   (op_a),
    .b   (op_b),
    .c   (op_c),
    .sum (sum),
    .le  (le)
  );

  assign cfg_ready = 1'b1;
  assign grow_dbl  = {grow_h, 1'b0};
  assign grow_ovf  = (grow_dbl > COORD_MAX);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      spk_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = allow_rotation ? spk_pkg::ST_ROT_ORDER : spk_pkg::ST_NR_FIT;
        end
      end
      spk_pkg::ST_NR_FIT:    state_next = le ? spk_pkg::ST_NEED : spk_pkg::ST_CLOSE;
      spk_pkg::ST_CLOSE:     state_next = allow_rotation ? spk_pkg::ST_ROT_PICK : spk_pkg::ST_WIDE;
      spk_pkg::ST_WIDE:      state_next = le ? spk_pkg::ST_NEED : spk_pkg::ST_OUT;
      spk_pkg::ST_ROT_ORDER: state_next = spk_pkg::ST_ROT_UP;
      spk_pkg::ST_ROT_UP:    state_next = le ? spk_pkg::ST_ROT_UPW : spk_pkg::ST_ROT_FLAT;
      spk_pkg::ST_ROT_UPW: begin
        state_next = (le || pw == '0) ? spk_pkg::ST_PUT : spk_pkg::ST_ROT_FLAT;
      end
      spk_pkg::ST_ROT_FLAT: begin
        state_next = (le || ph == '0) ? spk_pkg::ST_ROT_FLATH : spk_pkg::ST_CLOSE;
      end
      spk_pkg::ST_ROT_FLATH: begin
        state_next = (le || pw == '0) ? spk_pkg::ST_PUT : spk_pkg::ST_CLOSE;
      end
      spk_pkg::ST_ROT_PICK:  state_next = le ? spk_pkg::ST_NEED : spk_pkg::ST_WIDE;
      spk_pkg::ST_NEED: begin
        if (le) begin
          state_next = spk_pkg::ST_PUT;
        end else begin
          state_next = allow_growth ? spk_pkg::ST_GROW : spk_pkg::ST_OUT;
        end
      end
      spk_pkg::ST_GROW: begin
        if (le) begin
          state_next = spk_pkg::ST_PUT;
        end else if (grow_ovf) begin
          state_next = spk_pkg::ST_OUT;
        end
      end
      spk_pkg::ST_PUT:       state_next = spk_pkg::ST_SHELF;
      spk_pkg::ST_SHELF:     state_next = spk_pkg::ST_OUT;
      spk_pkg::ST_OUT:       state_next = out_free ? spk_pkg::ST_IDLE : spk_pkg::ST_OUT;
      default:               state_next = spk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == spk_pkg::ST_IDLE);
    op_a = '0;
    op_b = '0;
    op_c = '0;
    case (state)
      spk_pkg::ST_NR_FIT: begin
        op_a = UW'(fill);
        op_b = UW'(pw);
        op_c = UW'(atlas_width);
      end
      spk_pkg::ST_CLOSE: begin
        op_a = UW'(used);
        op_b = UW'(shelf_h);
        op_c = COORD_MAX;
      end
      spk_pkg::ST_WIDE: begin
        op_a = UW'(pw);
        op_c = UW'(atlas_width);
      end
      spk_pkg::ST_ROT_ORDER: begin
        op_a = UW'(ph);
        op_c = UW'(pw);
      end
      spk_pkg::ST_ROT_UP: begin
        op_a = UW'(ph);
        op_c = UW'(shelf_h);
      end
      spk_pkg::ST_ROT_UPW: begin
        op_a = UW'(fill);
        op_b = UW'(pw);
        op_c = UW'(atlas_width);
      end
      spk_pkg::ST_ROT_FLAT: begin
        op_a = UW'(fill);
        op_b = UW'(ph);
        op_c = UW'(atlas_width);
      end
      spk_pkg::ST_ROT_FLATH: begin
        op_a = UW'(used);
        op_b = UW'(pw);
        op_c = UW'(atlas);
      end
      spk_pkg::ST_ROT_PICK: begin
        op_a = UW'(ph);
        op_c = UW'(atlas_width);
      end
      spk_pkg::ST_NEED: begin
        op_a = UW'(used);
        op_b = UW'(ph);
        op_c = UW'(atlas);
      end
      spk_pkg::ST_GROW: begin
        op_a = need;
        op_c = UW'(grow_h);
      end
      spk_pkg::ST_PUT: begin
        op_a = UW'(fill);
        op_b = UW'(pw);
      end
      spk_pkg::ST_SHELF: begin
        op_a = UW'(ph);
        op_c = UW'(shelf_h);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= spk_pkg::ST_IDLE;
      atlas_width    <= spk_pkg::ATLAS_WIDTH_RESET;
      allow_rotation <= 1'b0;
      allow_growth   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          spk_pkg::REG_ATLAS_WIDTH:    atlas_width    <= cfg_data;
          spk_pkg::REG_ALLOW_ROTATION: allow_rotation <= cfg_data[0];
          spk_pkg::REG_ALLOW_GROWTH:   allow_growth   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      shelf_h <= '0;
      used    <= '0;
      atlas   <= SW'(spk_pkg::INIT_HEIGHT_RESET);
    end else begin
      case (state)
        spk_pkg::ST_CLOSE: begin
          used    <= le ? sum[SW-1:0] : COORD_MAX[SW-1:0];
          fill    <= '0;
          shelf_h <= '0;
        end
        spk_pkg::ST_GROW: begin
          if (le) begin
            atlas <= grow_h;
          end
        end
        spk_pkg::ST_PUT: begin
          fill <= sum[SW-1:0];
        end
        spk_pkg::ST_SHELF: begin
          if (!le) begin
            shelf_h <= SW'(ph);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      spk_pkg::ST_IDLE: begin
        if (in_valid) begin
          pw <= rect_width;
          ph <= rect_height;
          ok <= 1'b0;
        end
      end
      spk_pkg::ST_ROT_ORDER, spk_pkg::ST_ROT_PICK: begin
        if (le) begin
          pw <= ph;
          ph <= pw;
        end
      end
      spk_pkg::ST_ROT_FLATH: begin
        if (le || pw == '0) begin
          pw <= ph;
          ph <= pw;
        end
      end
      spk_pkg::ST_NEED: begin
        need   <= sum[UW-1:0];
        grow_h <= (atlas == '0) ? SW'(1) : atlas;
      end
      spk_pkg::ST_GROW: begin
        grow_h <= grow_dbl[SW-1:0];
      end
      spk_pkg::ST_PUT: begin
        px <= fill[FB-1:0];
        py <= used[FB-1:0];
        ok <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == spk_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spk_pkg::ST_OUT && out_free) begin
      placed           <= ok;
      pos_x            <= ok ? px : '0;
      pos_y            <= ok ? py : '0;
      placed_width     <= ok ? pw : '0;
      placed_height    <= ok ? ph : '0;
      atlas_height_now <= atlas[FB-1:0];
    end
  end

endmodule

@@ sim/placement_checker.sv @@
`timescale 1ns / 100ps

module placement_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        placed,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] placed_width,
  input  logic [15:0] placed_height,
  input  logic [15:0] atlas_height_now,
  output int          errors,
  output int          pending,
  output int          placed_cnt,
  output int          rejected_cnt,
  output logic [15:0] atlas_peak
);

  localparam logic [31:0] COORD_LIMIT = 32'h0000_FFFF;

  typedef struct packed {
    logic        ok;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] atlas;
  } placement_t;

  placement_t placement_q[$];

  logic [15:0] cfg_width;
  logic [15:0] cfg_init_h;
  logic        cfg_rot;
  logic        cfg_grow;

  logic [15:0] fill_w;
  logic [15:0] shelf_h;
  logic [15:0] used_h;
  logic [15:0] atlas_h;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic close_current_shelf();
    logic [31:0] sum;
    sum = used_h + shelf_h;
    used_h = (sum > COORD_LIMIT) ? COORD_LIMIT[15:0] : sum[15:0];
    fill_w = '0;
    shelf_h = '0;
  endtask

  task automatic stack_on_shelf(input logic [15:0] w, h, output logic [15:0] px, py);
    px = fill_w;
    py = used_h;
    fill_w = fill_w + w;
    if (h > shelf_h) shelf_h = h;
  endtask

  task automatic try_place(input logic [15:0] w, h, output logic ok,
                           output logic [15:0] px, py);
    logic [31:0] need;
    logic [31:0] g;
    ok = 1'b1;
    px = '0;
    py = '0;
    need = used_h + h;
    if (need > atlas_h) begin
      if (!cfg_grow) begin
        ok = 1'b0;
      end else begin
        g = (atlas_h == 16'd0) ? 32'd1 : {16'd0, atlas_h};
        while (ok && g < need) begin
          g = g << 1;
          if (g > COORD_LIMIT) ok = 1'b0;
        end
        if (ok) atlas_h = g[15:0];
      end
    end
    if (ok) stack_on_shelf(w, h, px, py);
  endtask

  task automatic predict_placement(input logic [15:0] w, h, output placement_t r);
    logic [15:0] lo, hi, pw, ph, px, py;
    logic [31:0] span, room_w, room_h;
    logic        ok;
    pw = w;
    ph = h;
    px = '0;
    py = '0;
    if (!cfg_rot) begin
      span = fill_w + w;
      if (span > cfg_width) begin
        close_current_shelf();
        if (w <= cfg_width) try_place(w, h, ok, px, py);
        else ok = 1'b0;
      end else begin
        try_place(w, h, ok, px, py);
      end
    end else begin
      lo = (w < h) ? w : h;
      hi = (w < h) ? h : w;
      room_w = (cfg_width > fill_w) ? cfg_width - fill_w : 32'd0;
      room_h = (atlas_h > used_h) ? atlas_h - used_h : 32'd0;
      if (shelf_h >= hi && room_w >= lo) begin
        pw = lo;
        ph = hi;
        stack_on_shelf(pw, ph, px, py);
        ok = 1'b1;
      end else if (room_w >= hi && room_h >= lo) begin
        pw = hi;
        ph = lo;
        stack_on_shelf(pw, ph, px, py);
        ok = 1'b1;
      end else begin
        close_current_shelf();
        if (hi > cfg_width) begin
          pw = lo;
          ph = hi;
        end else begin
          pw = hi;
          ph = lo;
        end
        if (pw <= cfg_width) try_place(pw, ph, ok, px, py);
        else ok = 1'b0;
      end
    end
    if (!ok) begin
      px = '0;
      py = '0;
      pw = '0;
      ph = '0;
    end
    r.ok = ok;
    r.x = px;
    r.y = py;
    r.w = pw;
    r.h = ph;
    r.atlas = atlas_h;
  endtask

  always @(posedge clk) begin : watch
    placement_t want;
    if (rst) begin
      placement_q.delete();
      cfg_width = spk_pkg::ATLAS_WIDTH_RESET;
      cfg_init_h = spk_pkg::INIT_HEIGHT_RESET;
      cfg_rot = 1'b0;
      cfg_grow = 1'b0;
      fill_w = '0;
      shelf_h = '0;
      used_h = '0;
      atlas_h = cfg_init_h;
      errors = 0;
      placed_cnt = 0;
      rejected_cnt = 0;
      atlas_peak = spk_pkg::INIT_HEIGHT_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          flag_mismatch("result with nothing expected, pos_x", pos_x, 16'd0);
        end else begin
          want = placement_q.pop_front();
          if (placed !== want.ok) flag_mismatch("placed", {15'd0, placed}, {15'd0, want.ok});
          if (pos_x !== want.x) flag_mismatch("pos_x", pos_x, want.x);
          if (pos_y !== want.y) flag_mismatch("pos_y", pos_y, want.y);
          if (placed_width !== want.w) flag_mismatch("placed_width", placed_width, want.w);
          if (placed_height !== want.h) flag_mismatch("placed_height", placed_height, want.h);
          if (atlas_height_now !== want.atlas)
            flag_mismatch("atlas_height_now", atlas_height_now, want.atlas);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          spk_pkg::REG_ATLAS_WIDTH:    cfg_width = cfg_data;
          spk_pkg::REG_INIT_HEIGHT:    cfg_init_h = cfg_data;
          spk_pkg::REG_ALLOW_ROTATION: cfg_rot = cfg_data[0];
          spk_pkg::REG_ALLOW_GROWTH:   cfg_grow = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_placement(rect_width, rect_height, want);
        placement_q.push_back(want);
        if (want.ok) placed_cnt++;
        else rejected_cnt++;
        if (atlas_h > atlas_peak) atlas_peak = atlas_h;
      end
    end
    pending = placement_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic        out_valid;
  logic        out_ready;
  logic        placed;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] placed_width;
  logic [15:0] placed_height;
  logic [15:0] atlas_height_now;

  int          mismatches;
  int          outstanding;
  int          placed_cnt;
  int          rejected_cnt;
  logic [15:0] atlas_peak;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles;

  always #5 clk = ~clk;

  shelf_rect_packer_core uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .rect_width(rect_width), .rect_height(rect_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .placed(placed), .pos_x(pos_x), .pos_y(pos_y),
    .placed_width(placed_width), .placed_height(placed_height),
    .atlas_height_now(atlas_height_now)
  );

  placement_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .rect_width(rect_width), .rect_height(rect_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .placed(placed), .pos_x(pos_x), .pos_y(pos_y),
    .placed_width(placed_width), .placed_height(placed_height),
    .atlas_height_now(atlas_height_now),
    .errors(mismatches), .pending(outstanding),
    .placed_cnt(placed_cnt), .rejected_cnt(rejected_cnt),
    .atlas_peak(atlas_peak)
  );

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_rect(input logic [15:0] w, h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rect_width <= w;
    rect_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] width, init_h, input logic rot, grow);
    wait_drained();
    write_reg(spk_pkg::REG_ATLAS_WIDTH, width);
    write_reg(spk_pkg::REG_INIT_HEIGHT, init_h);
    write_reg(spk_pkg::REG_ALLOW_ROTATION, {15'd0, rot});
    write_reg(spk_pkg::REG_ALLOW_GROWTH, {15'd0, grow});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, idle_pct, stall_pct, max_w, max_h, noise_pct);
    logic [15:0] w, h;
    int          sel;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < noise_pct) begin
        w = 16'($urandom);
        h = 16'($urandom);
      end else if (sel < noise_pct + 15) begin
        w = 16'($urandom_range(max_w / 4));
        h = 16'($urandom_range(2 * max_h));
      end else begin
        w = 16'($urandom_range(max_w));
        h = 16'($urandom_range(max_h));
      end
      send_rect(w, h);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rect_width = '0;
    rect_height = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    set_config(spk_pkg::ATLAS_WIDTH_RESET, spk_pkg::INIT_HEIGHT_RESET, 1'b0, 1'b0);
    send_rect(16'd0, 16'd0);
    send_rect(16'd5, 16'd3);
    send_rect(16'd1019, 16'd2);
    send_rect(16'd0, 16'd0);
    send_rect(16'd1024, 16'd1);
    send_rect(16'd1025, 16'd1);
    send_rect(16'hFFFF, 16'hFFFF);
    send_rect(16'd10, 16'd1020);
    send_rect(16'd10, 16'd1021);
    send_rect(16'd0, 16'hFFFF);

    set_config(16'd1024, spk_pkg::INIT_HEIGHT_RESET, 1'b1, 1'b0);
    send_rect(16'd5, 16'd1000);
    send_rect(16'd1000, 16'd5);
    send_rect(16'd2000, 16'd2000);
    send_rect(16'd3, 16'd2000);
    send_rect(16'd40, 16'd30);
    send_rect(16'd30, 16'd40);
    send_rect(16'd0, 16'd0);

    set_config(16'd1024, spk_pkg::INIT_HEIGHT_RESET, 1'b1, 1'b1);
    send_rect(16'd1, 16'hFFFF);
    send_rect(16'd700, 16'd1100);
    send_rect(16'hFFFF, 16'd1);

    set_config(16'hFFFF, spk_pkg::INIT_HEIGHT_RESET, 1'b0, 1'b1);
    send_rect(16'hFFFF, 16'd1);
    send_rect(16'hFFFF, 16'hFFFF);

    set_config(16'd1024, 16'd1, 1'b0, 1'b0);
    run_phase(350, 0, 0, 64, 16, 6);
    set_config(16'd1024, 16'hFFFF, 1'b1, 1'b0);
    run_phase(350, 53, 0, 64, 16, 6);
    set_config(16'd777, 16'd500, 1'b0, 1'b0);
    run_phase(250, 30, 30, 100, 20, 6);
    set_config(16'd1, spk_pkg::INIT_HEIGHT_RESET, 1'b1, 1'b1);
    run_phase(120, 0, 53, 3, 6, 0);
    set_config(16'hFFFF, spk_pkg::INIT_HEIGHT_RESET, 1'b0, 1'b1);
    run_phase(350, 30, 30, 4000, 24, 0);

    set_config(16'd300, 16'd2048, 1'b1, 1'b1);
    run_phase(150, 0, 0, 80, 40, 0);
    hold_off = 1'b1;
    run_phase(40, 0, 0, 80, 40, 0);
    wait_drained();
    run_phase(110, 53, 53, 80, 40, 0);

    set_config(16'hFFFF, spk_pkg::INIT_HEIGHT_RESET, 1'b1, 1'b1);
    run_phase(150, 0, 53, 8000, 8000, 10);

    wait_drained();
    repeat (40) @(negedge clk);
    $display("%0d rectangles checked over eleven register settings: %0d placed, %0d rejected.",
             placed_cnt + rejected_cnt, placed_cnt, rejected_cnt);
    $display("Rotation, growth up to height %0d, width changes and output hold-off covered.",
             atlas_peak);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
